@@ rtl/acpm_pkg.sv @@
// acpm_pkg: shared types and constants of the ac power / rms meter
// no dependencies
`default_nettype none

package acpm_pkg;

  localparam int ALPHA_BITS = 16;
  typedef logic [ALPHA_BITS-1:0] alpha_t;
  localparam alpha_t ALPHA_RESET = 16'd41;

  // rms form factor 1.11072 in q1.14
  localparam int FORM_BITS = 15;
  localparam int FORM_SHIFT = 14;
  localparam logic [FORM_BITS-1:0] FORM_Q14 = 15'd18198;

endpackage

`default_nettype wire

@@ rtl/acpm_if.sv @@
// acpm channel interfaces: sample input, result output, coefficient write
// depends on acpm_pkg
`default_nettype none

interface acpm_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] v_sample;
  logic signed [SAMPLE_BITS-1:0] i_sample;

  modport source(output valid, v_sample, i_sample, input ready);
  modport sink(input valid, v_sample, i_sample, output ready);
endinterface

interface acpm_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                            valid;
  logic                            ready;
  logic signed [2*SAMPLE_BITS-1:0] avg_power;
  logic        [SAMPLE_BITS-1:0]   v_rms;
  logic        [SAMPLE_BITS-1:0]   i_rms;

  modport source(output valid, avg_power, v_rms, i_rms, input ready);
  modport sink(input valid, avg_power, v_rms, i_rms, output ready);
endinterface

interface acpm_cfg_if
  import acpm_pkg::*;
();
  logic   valid;
  logic   ready;
  alpha_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/ac_power_rms_meter_core.sv @@
// ac_power_rms_meter_core: top level, coefficient register, front, queue and back
// depends on acpm_pkg, acpm_if, acpm_front, acpm_fifo, acpm_back
//
//   channel  dir  handshake     beat contents
//   sample   in   valid/ready   v_sample, i_sample
//   result   out  valid/ready   avg_power, v_rms, i_rms
//   cfg      in   valid/ready   data (smoothing coefficient, always ready)
//
// in steady state each beat takes six passes through the single shared alpha
// multiplier, two more steps to finish the current update, and the result load.
// synchronous active-high reset clears the averages to zero and the coefficient to 41.
// front and back are parted by a two-entry queue; a stalled result holds the back
// in its last step while the front keeps filling the queue.
`default_nettype none

module ac_power_rms_meter_core
  import acpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  acpm_in_if.sink    sample,
  acpm_out_if.source result,
  acpm_cfg_if.sink   cfg
);

  localparam int PW = 2*SAMPLE_BITS + FRAC_BITS;
  localparam int AW = SAMPLE_BITS + FRAC_BITS;
  localparam int QW = PW + 2*AW;

  alpha_t         coeff;
  logic           push_valid;
  logic           push_ready;
  logic [PW-1:0]  px;
  logic [AW-1:0]  vx;
  logic [AW-1:0]  ix;
  logic           pop_valid;
  logic           pop_ready;
  logic [QW-1:0]  pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= ALPHA_RESET;
    end else if (cfg.valid) begin
      coeff <= cfg.data;
    end
  end

  acpm_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .px        (px),
    .vx        (vx),
    .ix        (ix)
  );

  acpm_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({px, vx, ix}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  acpm_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .coeff    (coeff),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .px       (pop_data[QW-1 -: PW]),
    .vx       (pop_data[2*AW-1 -: AW]),
    .ix       (pop_data[AW-1:0]),
    .result   (result)
  );

endmodule

`default_nettype wire

@@ rtl/acpm_front.sv @@
// acpm_front: sample register, instantaneous power and magnitudes
// depends on acpm_if
`default_nettype none

module acpm_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  acpm_in_if.sink                                   sample,
  output logic                                      push_valid,
  input  wire logic                                 push_ready,
  output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]        px,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]          vx,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]          ix
);

  logic                            fv;
  logic signed [SAMPLE_BITS-1:0]   v_r;
  logic signed [SAMPLE_BITS-1:0]   i_r;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic        [SAMPLE_BITS-1:0]   v_mag;
  logic        [SAMPLE_BITS-1:0]   i_mag;

  assign sample.ready = !fv || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (sample.ready) begin
      fv <= sample.valid;
    end
    if (sample.ready && sample.valid) begin
      v_r <= sample.v_sample;
      i_r <= sample.i_sample;
    end
  end

  always_comb begin
    prod  = (2*SAMPLE_BITS)'(v_r) * (2*SAMPLE_BITS)'(i_r);
    v_mag = v_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v_r) : SAMPLE_BITS'(v_r);
    i_mag = i_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_r) : SAMPLE_BITS'(i_r);
  end

  assign push_valid = fv;
  assign px = {prod, {FRAC_BITS{1'b0}}};
  assign vx = {v_mag, {FRAC_BITS{1'b0}}};
  assign ix = {i_mag, {FRAC_BITS{1'b0}}};

endmodule

`default_nettype wire

@@ rtl/acpm_fifo.sv @@
// acpm_fifo: short flop queue between front and back
// no dependencies
`default_nettype none

module acpm_fifo #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  cnt;
  logic             push;
  logic             pop;

  assign push_ready = cnt != CNTW'(DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CNTW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNTW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/acpm_back.sv @@
// acpm_back: filter sequencer on one shared multiplier, state and result register
// depends on acpm_pkg, acpm_if
`default_nettype none

module acpm_back
  import acpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire alpha_t                               coeff,
  input  wire logic                                 pop_valid,
  output logic                                      pop_ready,
  input  wire logic [2*SAMPLE_BITS+FRAC_BITS-1:0]   px,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]     vx,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]     ix,
  acpm_out_if.source                                result
);

  localparam int PW    = 2*SAMPLE_BITS + FRAC_BITS;
  localparam int AW    = SAMPLE_BITS + FRAC_BITS;
  localparam int DW    = PW + 1;
  localparam int LOWB  = DW / 2;
  localparam int MB    = DW - LOWB + 1;
  localparam int PRW   = ALPHA_BITS + 1 + MB;
  localparam int FULLW = DW + ALPHA_BITS + 2;
  localparam int RW    = AW + FORM_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P_LO = 4'd1;
  localparam logic [3:0] ST_P_HI = 4'd2;
  localparam logic [3:0] ST_V_LO = 4'd3;
  localparam logic [3:0] ST_V_HI = 4'd4;
  localparam logic [3:0] ST_I_LO = 4'd5;
  localparam logic [3:0] ST_I_HI = 4'd6;
  localparam logic [3:0] ST_I_SUM = 4'd7;
  localparam logic [3:0] ST_I_UPD = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]              step;
  logic [3:0]              step_next;
  logic [PW-1:0]           pa;
  logic [AW-1:0]           va;
  logic [AW-1:0]           ia;
  logic [DW-1:0]           dp;
  logic [DW-1:0]           dv;
  logic [DW-1:0]           di;
  logic signed [ALPHA_BITS:0] mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [PRW-1:0]   prod;
  logic signed [PRW-1:0]   lo_keep;
  logic signed [FULLW-1:0] full_hi;
  logic signed [FULLW-1:0] full;
  logic [DW-1:0]           inc;
  logic [RW-1:0]           v_rw;
  logic [RW-1:0]           i_rw;
  logic                    out_free;
  logic                    pop;
  logic                    load_out;

  function automatic logic signed [MB-1:0] lo_part(input logic [DW-1:0] d);
    lo_part = MB'({1'b0, d[LOWB-1:0]});
  endfunction

  function automatic logic signed [MB-1:0] hi_part(input logic [DW-1:0] d);
    hi_part = {d[DW-1], d[DW-1:LOWB]};
  endfunction

  assign out_free  = !result.valid || result.ready;
  assign pop_ready = (step == ST_IDLE) || ((step == ST_DONE) && out_free);
  assign pop       = pop_valid && pop_ready;
  assign load_out  = (step == ST_DONE) && out_free;

  always_comb begin
    mul_a = {1'b0, coeff};
    unique case (step)
      ST_P_LO: mul_b = lo_part(dp);
      ST_P_HI: mul_b = hi_part(dp);
      ST_V_LO: mul_b = lo_part(dv);
      ST_V_HI: mul_b = hi_part(dv);
      ST_I_LO: mul_b = lo_part(di);
      ST_I_HI: mul_b = hi_part(di);
      default: mul_b = lo_part(dp);
    endcase
  end

  always_comb begin
    full_hi = FULLW'(prod);
    full    = (full_hi <<< LOWB) + FULLW'(lo_keep);
  end

  always_comb begin
    unique case (step)
      ST_IDLE:  step_next = pop_valid ? ST_P_LO : ST_IDLE;
      ST_P_LO:  step_next = ST_P_HI;
      ST_P_HI:  step_next = ST_V_LO;
      ST_V_LO:  step_next = ST_V_HI;
      ST_V_HI:  step_next = ST_I_LO;
      ST_I_LO:  step_next = ST_I_HI;
      ST_I_HI:  step_next = ST_I_SUM;
      ST_I_SUM: step_next = ST_I_UPD;
      ST_I_UPD: step_next = ST_DONE;
      ST_DONE:  step_next = !out_free ? ST_DONE : (pop_valid ? ST_P_LO : ST_IDLE);
      default:  step_next = ST_IDLE;
    endcase
  end

  assign v_rw = RW'(va) * RW'(FORM_Q14);
  assign i_rw = RW'(ia) * RW'(FORM_Q14);

  always_ff @(posedge clk) begin
    prod    <= PRW'(mul_a) * PRW'(mul_b);
    lo_keep <= prod;
    inc     <= full[ALPHA_BITS +: DW];
    if (pop) begin
      dp <= {px[PW-1], px} - {pa[PW-1], pa};
      dv <= {{(DW-AW){1'b0}}, vx} - {{(DW-AW){1'b0}}, va};
      di <= {{(DW-AW){1'b0}}, ix} - {{(DW-AW){1'b0}}, ia};
    end
    if (load_out) begin
      result.avg_power <= pa[PW-1:FRAC_BITS];
      result.v_rms     <= v_rw[FORM_SHIFT+FRAC_BITS +: SAMPLE_BITS];
      result.i_rms     <= i_rw[FORM_SHIFT+FRAC_BITS +: SAMPLE_BITS];
    end
    if (rst) begin
      step         <= ST_IDLE;
      pa           <= '0;
      va           <= '0;
      ia           <= '0;
      result.valid <= 1'b0;
    end else begin
      step <= step_next;
      if (step == ST_V_HI) begin
        pa <= pa + inc[PW-1:0];
      end
      if (step == ST_I_HI) begin
        va <= va + inc[AW-1:0];
      end
      if (step == ST_I_UPD) begin
        ia <= ia + inc[AW-1:0];
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/acpm_meter_checker.sv @@
`timescale 1ns / 100ps
// acpm_meter_checker: watches the sample, result and coefficient channels of the meter,
// predicts each result beat and compares it field by field
// depends on acpm_pkg and acpm_if

module acpm_meter_checker
  import acpm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  acpm_in_if   sample,
  acpm_out_if  result,
  acpm_cfg_if  cfg,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    logic signed [2*SAMPLE_BITS-1:0] avg_power;
    logic        [SAMPLE_BITS-1:0]   v_rms;
    logic        [SAMPLE_BITS-1:0]   i_rms;
  } reading_t;

  reading_t reading_q[$];
  alpha_t   coeff;
  longint   power_avg;
  longint   volt_avg;
  longint   curr_avg;
  int       fail_count;

  // floor(a * diff / 2^16), wide enough for any power difference
  function automatic longint ema_increment(alpha_t a, longint diff);
    logic signed [ALPHA_BITS+65:0] prod;
    prod = diff * $signed({1'b0, a});
    return longint'(prod >>> ALPHA_BITS);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rms_of(longint avg);
    longint prod;
    prod = avg * longint'(FORM_Q14);
    return prod[FORM_SHIFT+FRAC_BITS +: SAMPLE_BITS];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic predict_reading(input logic signed [SAMPLE_BITS-1:0] v,
                                 input logic signed [SAMPLE_BITS-1:0] i);
    longint   power;
    longint   v_mag;
    longint   i_mag;
    reading_t r;
    power = (longint'(v) * longint'(i)) <<< FRAC_BITS;
    v_mag = (v < 0) ? -longint'(v) : longint'(v);
    i_mag = (i < 0) ? -longint'(i) : longint'(i);
    power_avg += ema_increment(coeff, power - power_avg);
    volt_avg  += ema_increment(coeff, (v_mag <<< FRAC_BITS) - volt_avg);
    curr_avg  += ema_increment(coeff, (i_mag <<< FRAC_BITS) - curr_avg);
    r.avg_power = power_avg >>> FRAC_BITS;
    r.v_rms     = rms_of(volt_avg);
    r.i_rms     = rms_of(curr_avg);
    reading_q.push_back(r);
  endtask

  task automatic check_reading();
    reading_t want;
    if (reading_q.size() == 0) begin
      report_mismatch($sformatf("result beat with no sample pending, avg_power %0d",
                                result.avg_power));
    end else begin
      want = reading_q.pop_front();
      if (result.avg_power !== want.avg_power) begin
        report_mismatch($sformatf("avg_power got %0d expected %0d",
                                  result.avg_power, want.avg_power));
      end
      if (result.v_rms !== want.v_rms) begin
        report_mismatch($sformatf("v_rms got %0d expected %0d", result.v_rms, want.v_rms));
      end
      if (result.i_rms !== want.i_rms) begin
        report_mismatch($sformatf("i_rms got %0d expected %0d", result.i_rms, want.i_rms));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reading_q.delete();
      coeff     = ALPHA_RESET;
      power_avg = 0;
      volt_avg  = 0;
      curr_avg  = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        coeff = cfg.data;
      end
      if (sample.valid && sample.ready) begin
        predict_reading(sample.v_sample, sample.i_sample);
      end
      if (result.valid && result.ready) begin
        check_reading();
      end
    end
    pending <= reading_q.size();
    fails   <= fail_count;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: clock, reset and stimulus for ac_power_rms_meter_core with random idling on
// both channels; depends on acpm_pkg, acpm_if, the core and acpm_meter_checker

module tb_top;
  import acpm_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_BEATS   = 110;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  int   beats_sent;
  int   coeff_writes;
  int   quiet_cycles;
  bit   no_idle;

  acpm_in_if  sample_ch ();
  acpm_out_if result_ch ();
  acpm_cfg_if cfg_ch ();

  ac_power_rms_meter_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  acpm_meter_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #1 clk = ~clk;

  function automatic logic signed [15:0] rand_field();
    logic signed [15:0] corner [5];
    corner = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};
    case ($urandom_range(0, 7))
      0: return corner[$urandom_range(0, 4)];
      1: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] v, input logic signed [15:0] i);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.v_sample <= v;
    sample_ch.i_sample <= i;
    do @(posedge clk); while (!sample_ch.ready);
    beats_sent++;
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_coeff(input alpha_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    coeff_writes++;
  endtask

  // result side
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    alpha_t             coeff;
    int                 count;
    bit                 paused;
    logic signed [15:0] v_pick;
    logic signed [15:0] i_pick;
    rst                <= 1'b1;
    sample_ch.valid    <= 1'b0;
    sample_ch.v_sample <= '0;
    sample_ch.i_sample <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= ALPHA_RESET;
    no_idle = 1'b0;
    paused  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset coefficient, field extremes
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'shffff, 16'sh0001);
    drain_results();

    // fastest filter, most negative samples drive rms to its ceiling
    write_coeff(16'hffff);
    repeat (6) send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0001, 16'shffff);
    send_sample(16'sh0000, 16'sh0000);
    drain_results();

    // zero coefficient holds all averages
    write_coeff('0);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh1234, 16'shedcb);
    drain_results();

    write_coeff(16'd1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'shffff, 16'shffff);
    drain_results();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0: coeff = 16'hffff;
        1: coeff = 16'($urandom_range(1, 255));
        2: coeff = 16'($urandom);
        3: coeff = ALPHA_RESET;
        default: coeff = 16'($urandom_range(4096, 65535));
      endcase
      write_coeff(coeff);
      no_idle = (phase % 3 == 2);
      count = 0;
      while (count < PHASE_BEATS) begin
        if ($urandom_range(0, 3) == 0) begin
          // held pair lets the averages settle
          v_pick = rand_field();
          i_pick = rand_field();
          repeat ($urandom_range(8, 24)) begin
            send_sample(v_pick, i_pick);
            count++;
          end
        end else begin
          send_sample(rand_field(), rand_field());
          count++;
        end
        if (phase == 4 && !paused && count >= 50) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end
    no_idle = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d sample beats over %0d coefficient writes, 0, 1 and 65535 included",
             beats_sent, coeff_writes);
    $display("both channels idled 0 to 19 cycles per beat, with back-to-back stretches");
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
